[hdl/tss_pkg.sv]
// shared types, sizes, status codes and the divide-by-three helper
// for the ternary search table block; no dependencies
package tss_pkg;

  localparam int DEPTH     = 1024;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = IDX_W + 2;

  // item kinds on the input tuser
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // result status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_WRITE_DONE = 2'd3;

  // configuration register indexes
  localparam logic CFG_ELEMENT_COUNT  = 1'b0;
  localparam logic CFG_COMPARE_SIGNED = 1'b1;

  // reciprocal of three, exact for every value below 2**IDX_W
  localparam int DIV3_SHIFT = IDX_W + 1;
  localparam int DIV3_MUL   = ((2 ** DIV3_SHIFT) + 2) / 3;
  localparam int DIV3_PW    = IDX_W + DIV3_SHIFT;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
  } res_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  function automatic logic [IDX_W-1:0] div3(input logic [IDX_W-1:0] x);
    logic [DIV3_PW-1:0] prod;
    prod = DIV3_PW'(x) * DIV3_PW'(DIV3_MUL);
    return prod[DIV3_PW-1:DIV3_SHIFT];
  endfunction

endpackage

[hdl/ternary_search_sorted_table_top.sv]
// top level of the ternary search table: config registers, output register
// and wiring of tss_ctrl, tss_cmp and tss_ram; depends on tss_pkg
//
// usage:
//   in_*  : one beat per item. in_tuser is func (0 write, 1 search),
//           in_tdata carries entry_index and key_value.
//   out_* : one result beat per item. out_tuser is status
//           (0 found, 1 not found, 2 empty, 3 write done), out_tdata
//           carries found_index (zero unless found).
//   cfg_* : register writes, index 0 element_count, 1 compare_signed;
//           cfg_ready is high whenever out of reset. write only when idle.
// sequence: a write or an empty-table search goes from the accept beat to
//   the done state, then into the output register. a search round steps
//   through bound computation, first probe read, first compare and second
//   compare through the single comparator and single memory read port;
//   about 7 rounds for 1024 entries.
// throughput: one item at a time; in_tready is low from the accept beat
//   until the result moves into the output register.
// reset: control state and config registers clear and both readies are low;
//   table contents are left as they are and must be written before searched.
// stall: a result waiting on out_tready holds in the output register; the
//   next item may be accepted and worked on meanwhile, and its result waits
//   until the output register is free.
module ternary_search_sorted_table_top (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [9:0] entry_index, [41:10] key_value, rest zero
  input  logic [0:0]  in_tuser,   // [0] func
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] found_index, rest zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import tss_pkg::*;

  logic                 start;
  logic                 idle;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic [KEY_WIDTH-1:0] cmp_key;
  cmp_t                 cmp_res;
  logic                 res_valid;
  res_t                 res;
  logic                 res_take;

  logic [CNT_W-1:0]     element_count_r;
  logic                 compare_signed_r;
  logic                 out_valid_r;
  res_t                 out_res_r;

  assign in_tready = idle && rst_n;
  assign start     = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r  <= '0;
      compare_signed_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ELEMENT_COUNT:  element_count_r  <= cfg_data[CNT_W-1:0];
        CFG_COMPARE_SIGNED: compare_signed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output register
  assign res_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = 16'(out_res_r.index);

  tss_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .func          (in_tuser[0]),
    .entry_index   (in_tdata[IDX_W-1:0]),
    .key_value     (in_tdata[IDX_W+KEY_WIDTH-1:IDX_W]),
    .element_count (element_count_r),
    .idle          (idle),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .cmp_key       (cmp_key),
    .cmp_res       (cmp_res),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take)
  );

  tss_cmp u_cmp (
    .entry       (ram_rdata),
    .key         (cmp_key),
    .signed_mode (compare_signed_r),
    .res         (cmp_res)
  );

  tss_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hdl/tss_ram.sv]
// key table memory: one write port, one read port with registered data
// depends on tss_pkg
module tss_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [tss_pkg::IDX_W-1:0]     waddr,
  input  logic [tss_pkg::KEY_WIDTH-1:0] wdata,
  input  logic [tss_pkg::IDX_W-1:0]     raddr,
  output logic [tss_pkg::KEY_WIDTH-1:0] rdata
);
  import tss_pkg::*;

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/tss_cmp.sv]
// shared key comparator, unsigned or two's complement
// depends on tss_pkg
module tss_cmp (
  input  logic [tss_pkg::KEY_WIDTH-1:0] entry,
  input  logic [tss_pkg::KEY_WIDTH-1:0] key,
  input  logic                          signed_mode,
  output tss_pkg::cmp_t                 res
);
  import tss_pkg::*;

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] ea;
  logic [KEY_WIDTH-1:0] ka;

  // flipping the sign bit turns a signed compare into an unsigned one
  assign flip = signed_mode ? {1'b1, {(KEY_WIDTH-1){1'b0}}} : '0;
  assign ea   = entry ^ flip;
  assign ka   = key ^ flip;

  assign res.lt = ea < ka;
  assign res.eq = ea == ka;

endmodule

[hdl/tss_ctrl.sv]
// search sequencer: narrows lo/hi one round at a time, two probes per round
// through the shared comparator; depends on tss_pkg
module tss_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          func,
  input  logic [tss_pkg::IDX_W-1:0]     entry_index,
  input  logic [tss_pkg::KEY_WIDTH-1:0] key_value,
  input  logic [tss_pkg::CNT_W-1:0]     element_count,
  output logic                          idle,
  output logic                          ram_we,
  output logic [tss_pkg::IDX_W-1:0]     ram_waddr,
  output logic [tss_pkg::KEY_WIDTH-1:0] ram_wdata,
  output logic [tss_pkg::IDX_W-1:0]     ram_raddr,
  output logic [tss_pkg::KEY_WIDTH-1:0] cmp_key,
  input  tss_pkg::cmp_t                 cmp_res,
  output logic                          res_valid,
  output tss_pkg::res_t                 res,
  input  logic                          res_take
);
  import tss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_CMP1 = 3'd3;
  localparam logic [2:0] S_CMP2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic signed [POS_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]      p1_r, p1_nxt, p2_r, p2_nxt;
  logic                  r1_lt_r, r1_lt_nxt;
  res_t                  res_r, res_nxt;

  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      span;
  logic [IDX_W-1:0]      third;

  // clamp the live count to the table depth
  assign count = (element_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : element_count;

  // span only matters while lo <= hi, where it fits the index width
  assign span  = IDX_W'(hi_r - lo_r);
  assign third = div3(span);

  // table write happens on the accept beat itself
  assign ram_we    = start && (func == FUNC_WRITE);
  assign ram_waddr = entry_index;
  assign ram_wdata = key_value;
  assign ram_raddr = (state_r == S_CMP1) ? p2_r : p1_r;
  assign cmp_key   = key_r;

  assign idle      = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res       = res_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    r1_lt_nxt = r1_lt_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt.index = '0;
          if (func == FUNC_WRITE) begin
            res_nxt.status = ST_WRITE_DONE;
            state_nxt      = S_DONE;
          end else if (count == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            key_nxt   = key_value;
            lo_nxt    = '0;
            hi_nxt    = POS_W'(count) - POS_W'(1);
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (lo_r > hi_r) begin
          res_nxt.status = ST_NOT_FOUND;
          res_nxt.index  = '0;
          state_nxt      = S_DONE;
        end else begin
          p1_nxt    = lo_r[IDX_W-1:0] + third;
          p2_nxt    = hi_r[IDX_W-1:0] - third;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = S_CMP1;
      end
      S_CMP1: begin
        if (cmp_res.eq) begin
          res_nxt.status = ST_FOUND;
          res_nxt.index  = p1_r;
          state_nxt      = S_DONE;
        end else begin
          r1_lt_nxt = cmp_res.lt;
          state_nxt = S_CMP2;
        end
      end
      S_CMP2: begin
        if (cmp_res.eq) begin
          res_nxt.status = ST_FOUND;
          res_nxt.index  = p2_r;
          state_nxt      = S_DONE;
        end else begin
          // key between probes, above both, or below the first
          if (r1_lt_r && !cmp_res.lt) begin
            lo_nxt = POS_W'(p1_r) + POS_W'(1);
            hi_nxt = POS_W'(p2_r) - POS_W'(1);
          end else if (cmp_res.lt) begin
            lo_nxt = POS_W'(p2_r) + POS_W'(1);
          end else begin
            hi_nxt = POS_W'(p1_r) - POS_W'(1);
          end
          state_nxt = S_CALC;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    r1_lt_r <= r1_lt_nxt;
    res_r   <= res_nxt;
  end

endmodule

[hdl/tss_chk.sv]
// port-level checks for the ternary search table top, with its bind
// depends on tss_pkg and ternary_search_sorted_table_top
module tss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import tss_pkg::*;

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one item at a time: an accept beat closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept beat");

  // a result other than found carries a zero index
  a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_FOUND |-> out_tdata == 16'd0)
    else $error("nonzero index on a result that is not found");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

endmodule

bind ternary_search_sorted_table_top tss_chk u_tss_chk (.*);
